/* hw/rtl/buh_pkg.sv */
// Shared types and codes for the bounded undo/redo history block.
// Holds the command and response word layouts and the opcode, status and action codes.
// Depends on nothing; buh_ctrl and the top level import it.
package buh_pkg;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_MERGE = 3'd1,
        OP_UNDO  = 3'd2,
        OP_REDO  = 3'd3,
        OP_CLEAR = 3'd4,
        OP_QUERY = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STS_OK           = 2'd0,
        STS_EMPTY_NAME   = 2'd1,
        STS_STACK_EMPTY  = 2'd2,
        STS_MERGE_REFUSE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_UNDO = 2'd1,
        ACT_REDO = 2'd2
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } seq_state_t;

    localparam int CFG_W   = 9;
    localparam int HDL_W   = 16;
    localparam int TAG_W   = 16;
    localparam int COUNT_W = 9;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [TAG_W-1:0] name_tag;
        logic [HDL_W-1:0] undo_handle;
        logic [HDL_W-1:0] redo_handle;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         action;
        logic [HDL_W-1:0]   run_handle;
        logic [COUNT_W-1:0] undo_count;
        logic [COUNT_W-1:0] redo_count;
        logic [TAG_W-1:0]   top_tag;
    } rsp_word_t;

endpackage

/* hw/rtl/buh_mem.sv */
// Entry store of the history: one write port and two registered read ports.
// Depends on nothing; instantiated by the top level.
module buh_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* hw/rtl/buh_ctrl.sv */
// Command sequencer of the history: pointers, cached top tag, store accesses and response register.
// Depends on buh_pkg; drives the ports of buh_mem.
module buh_ctrl #(
    parameter int MAX_DEPTH = 256,
    parameter int TAG_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  buh_pkg::cmd_word_t                  cmd,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output buh_pkg::rsp_word_t                  rsp,
    input  logic [$clog2(MAX_DEPTH+1)-1:0]      limit,
    output logic                                rd_en,
    output logic [$clog2(MAX_DEPTH)-1:0]        raddr_a,
    output logic [$clog2(MAX_DEPTH)-1:0]        raddr_b,
    input  logic [((TAG_BITS < 16) ? TAG_BITS : 16)+31:0] rdata_a,
    input  logic [((TAG_BITS < 16) ? TAG_BITS : 16)+31:0] rdata_b,
    output logic                                we,
    output logic [$clog2(MAX_DEPTH)-1:0]        waddr,
    output logic [((TAG_BITS < 16) ? TAG_BITS : 16)+31:0] wdata
);
    import buh_pkg::*;

    localparam int AW   = $clog2(MAX_DEPTH);
    localparam int CW   = $clog2(MAX_DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int TB   = (TAG_BITS < 16) ? TAG_BITS : 16;
    localparam int EW   = TB + 32;
    localparam int OW   = (CW > COUNT_W) ? CW : COUNT_W;

    // Physical slot of logical position k counted from base; k never exceeds the depth.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(k);
        if (s >= SW'(MAX_DEPTH))
        begin
            s = s - SW'(MAX_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    seq_state_t state_reg;
    seq_state_t state_next;

    logic [AW-1:0] oldest_reg;
    logic [AW-1:0] oldest_next;
    logic [CW-1:0] undo_reg;
    logic [CW-1:0] undo_next;
    logic [CW-1:0] redo_reg;
    logic [CW-1:0] redo_next;
    logic [TB-1:0] top_reg;
    logic [TB-1:0] top_next;

    logic [2:0]       op_reg;
    logic [TB-1:0]    tag_reg;
    logic [HDL_W-1:0] uh_reg;
    logic [HDL_W-1:0] rh_reg;

    rsp_word_t rsp_reg;
    rsp_word_t rsp_next;
    logic      rsp_valid_reg;

    logic accept;
    logic commit;

    logic [CW-1:0] undo_m1;
    logic [CW-1:0] undo_m2;

    logic          push_full;
    logic [AW-1:0] push_o1;
    logic [CW-1:0] push_u1;
    logic [CW-1:0] push_u2;
    logic          push_evict;

    logic [HDL_W-1:0] handle;
    logic [OW-1:0]    undo_ext;
    logic [OW-1:0]    redo_ext;

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        cmd_ready = 1'b0;
        commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            ST_EXEC:
            begin
                commit = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign accept = cmd_valid && cmd_ready;

    assign undo_m1 = (undo_reg == '0) ? '0 : undo_reg - CW'(1);
    assign undo_m2 = (undo_reg < CW'(2)) ? '0 : undo_reg - CW'(2);

    // The store is read when the word is taken, so the data is ready in the execute cycle.
    assign rd_en   = accept;
    assign raddr_a = (cmd.opcode == OP_REDO) ? slot(oldest_reg, undo_reg)
                                             : slot(oldest_reg, undo_m1);
    assign raddr_b = slot(oldest_reg, undo_m2);

    // Push: make room when the store is full, write, then trim to the limit.
    assign push_full  = undo_reg >= CW'(MAX_DEPTH);
    assign push_o1    = push_full ? slot(oldest_reg, CW'(1)) : oldest_reg;
    assign push_u1    = push_full ? undo_reg - CW'(1) : undo_reg;
    assign push_u2    = push_u1 + CW'(1);
    assign push_evict = push_u2 > limit;

    always_comb
    begin
        oldest_next = oldest_reg;
        undo_next   = undo_reg;
        redo_next   = redo_reg;
        top_next    = top_reg;
        we          = 1'b0;
        waddr       = slot(oldest_reg, undo_m1);
        wdata       = {rdata_a[EW-1:32], rdata_a[31:16], rh_reg};
        handle      = '0;
        rsp_next.status = STS_OK;
        rsp_next.action = ACT_NONE;
        unique case (op_reg)
            OP_PUSH:
            begin
                if (tag_reg == '0)
                begin
                    rsp_next.status = STS_EMPTY_NAME;
                end
                else
                begin
                    we          = 1'b1;
                    waddr       = slot(push_o1, push_u1);
                    wdata       = {tag_reg, uh_reg, rh_reg};
                    oldest_next = push_evict ? slot(push_o1, CW'(1)) : push_o1;
                    undo_next   = push_evict ? push_u1 : push_u2;
                    redo_next   = '0;
                    top_next    = tag_reg;
                end
            end
            OP_MERGE:
            begin
                if (tag_reg == '0)
                begin
                    rsp_next.status = STS_EMPTY_NAME;
                end
                else if (undo_reg == '0 || redo_reg != '0 || top_reg != tag_reg)
                begin
                    rsp_next.status = STS_MERGE_REFUSE;
                end
                else
                begin
                    we = 1'b1;
                end
            end
            OP_UNDO:
            begin
                if (undo_reg == '0)
                begin
                    rsp_next.status = STS_STACK_EMPTY;
                end
                else
                begin
                    handle    = rdata_a[31:16];
                    undo_next = undo_m1;
                    redo_next = redo_reg + CW'(1);
                    top_next  = (undo_reg < CW'(2)) ? '0 : rdata_b[EW-1:32];
                    if (handle != '0)
                    begin
                        rsp_next.action = ACT_UNDO;
                    end
                end
            end
            OP_REDO:
            begin
                if (redo_reg == '0)
                begin
                    rsp_next.status = STS_STACK_EMPTY;
                end
                else
                begin
                    handle    = rdata_a[15:0];
                    undo_next = undo_reg + CW'(1);
                    redo_next = redo_reg - CW'(1);
                    top_next  = rdata_a[EW-1:32];
                    if (handle != '0)
                    begin
                        rsp_next.action = ACT_REDO;
                    end
                end
            end
            OP_CLEAR:
            begin
                undo_next = '0;
                redo_next = '0;
                top_next  = '0;
            end
            default:
            begin
                top_next = top_reg;
            end
        endcase
        we = we && commit;
        undo_ext = OW'(undo_next);
        redo_ext = OW'(redo_next);
        rsp_next.run_handle = handle;
        rsp_next.undo_count = undo_ext[COUNT_W-1:0];
        rsp_next.redo_count = redo_ext[COUNT_W-1:0];
        rsp_next.top_tag    = TAG_W'(top_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            undo_reg      <= '0;
            redo_reg      <= '0;
            top_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                oldest_reg    <= oldest_next;
                undo_reg      <= undo_next;
                redo_reg      <= redo_next;
                top_reg       <= top_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= cmd.opcode;
            tag_reg <= cmd.name_tag[TB-1:0];
            uh_reg  <= cmd.undo_handle;
            rh_reg  <= cmd.redo_handle;
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* hw/rtl/bounded_undo_redo_history_top.sv */
// Top level of the bounded undo/redo history: depth limit register, sequencer and entry store.
// Depends on buh_pkg, buh_mem and buh_ctrl.
//
//   channel   direction  handshake              word
//   cmd       in         cmd_valid / cmd_ready  buh_pkg::cmd_word_t
//   rsp       out        rsp_valid / rsp_ready  buh_pkg::rsp_word_t
//   cfg       in         cfg_valid / cfg_ready  depth limit, 9 bits
//
// Each command word is handled in the cycle it is taken, in which the entry store is read,
// and in an execute cycle that uses the registered read data and, for a push or merge,
// writes the store.
// A held response word stretches the execute cycle until the response register is free.
// Reset empties both sides and sets the limit to the full store, at most 256 entries;
// the store itself is not cleared. Config words are taken in any cycle.
module bounded_undo_redo_history_top #(
    parameter int MAX_DEPTH = 256,
    parameter int TAG_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  buh_pkg::cmd_word_t            cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output buh_pkg::rsp_word_t            rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [buh_pkg::CFG_W-1:0]     cfg_data
);
    import buh_pkg::*;

    localparam int AW      = $clog2(MAX_DEPTH);
    localparam int CW      = $clog2(MAX_DEPTH + 1);
    localparam int TB      = (TAG_BITS < 16) ? TAG_BITS : 16;
    localparam int EW      = TB + 32;
    localparam int LW      = (CW > CFG_W) ? CW : CFG_W;
    localparam int LIM_RST = (MAX_DEPTH < 256) ? MAX_DEPTH : 256;

    // The limit is kept in its effective form: zero or anything beyond the store means the
    // whole store.
    logic [CW-1:0] limit_reg;
    logic [CW-1:0] limit_next;

    logic          rd_en;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [EW-1:0] rdata_a;
    logic [EW-1:0] rdata_b;
    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cfg_data == '0 || LW'(cfg_data) > LW'(MAX_DEPTH))
        begin
            limit_next = CW'(MAX_DEPTH);
        end
        else
        begin
            limit_next = CW'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= CW'(LIM_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= limit_next;
        end
    end

    buh_ctrl #(
        .MAX_DEPTH (MAX_DEPTH),
        .TAG_BITS  (TAG_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .limit     (limit_reg),
        .rd_en     (rd_en),
        .raddr_a   (raddr_a),
        .raddr_b   (raddr_b),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata)
    );

    buh_mem #(
        .DEPTH (MAX_DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata)
    );

endmodule
